### rtl/ulr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the UTF-8 lossy repair unit.
package ulr_pkg;

   // Byte classes and Table 3-7 bounds
   localparam logic [7:0] ASCII_LIMIT   = 8'h80;
   localparam logic [7:0] LEAD_MIN      = 8'hC2;
   localparam logic [7:0] LEAD_MAX      = 8'hF4;
   localparam logic [7:0] LEAD_E0       = 8'hE0;
   localparam logic [7:0] LEAD_ED       = 8'hED;
   localparam logic [7:0] LEAD_F0       = 8'hF0;
   localparam logic [7:0] LEAD_F4       = 8'hF4;
   localparam logic [7:0] CONT_MIN      = 8'h80;
   localparam logic [7:0] CONT_MAX      = 8'hBF;
   localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
   localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
   localparam logic [7:0] F0_SECOND_MIN = 8'h90;
   localparam logic [7:0] F4_SECOND_MAX = 8'h8F;

   // U+FFFD encoded as UTF-8
   localparam logic [7:0] REPL_BYTE0 = 8'hEF;
   localparam logic [7:0] REPL_BYTE1 = 8'hBF;
   localparam logic [7:0] REPL_BYTE2 = 8'hBD;
   localparam logic [1:0] REPL_IDX0  = 2'd0;
   localparam logic [1:0] REPL_IDX1  = 2'd1;
   localparam logic [1:0] REPL_IDX2  = 2'd2;

   localparam int PEND_DEPTH  = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // One command per input transaction that emits anything: rep_cnt replacements, then data_cnt bytes.
   typedef struct packed {
      logic [1:0]      rep_cnt;
      logic [2:0]      data_cnt;
      logic [3:0][7:0] data;
      logic            last;
   } cmd_type;

   function automatic logic [7:0] repl_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         REPL_IDX0: b = REPL_BYTE0;
         REPL_IDX1: b = REPL_BYTE1;
         REPL_IDX2: b = REPL_BYTE2;
         default:   b = REPL_BYTE2;
      endcase
      return b;
   endfunction

endpackage

### rtl/ulr_if.sv
`timescale 1ns / 1ps
// Channel interfaces for raw input bytes and repaired output bytes.
interface ulr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ulr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       from_replacement;
   logic       out_last;
   modport source (output valid, output out_byte, output from_replacement,
                   output out_last, input ready);
   modport sink   (input valid, input out_byte, input from_replacement,
                   input out_last, output ready);
endinterface

### rtl/ulr_front.sv
`timescale 1ns / 1ps
// Front end: holds the partial sequence and classifies each input byte, pushing a command for each that emits output.
module ulr_front (
   input  logic            clock,
   input  logic            reset,
   ulr_req_if.sink         req_ch,
   input  logic            q_full,
   output logic            q_push,
   output ulr_pkg::cmd_type q_cmd
);
   import ulr_pkg::*;

   logic [7:0] pend_ff [PEND_DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic       accept;
   logic [7:0] b, lead, lo, hi;
   logic [2:0] need;
   logic       in_range, last, start, store;
   logic [1:0] store_idx, flush_n, rep;
   logic [2:0] n_data;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign b            = req_ch.in_byte;
   assign last         = req_ch.in_last;
   assign lead         = pend_ff[0];

   always_comb begin
      lo = CONT_MIN;
      hi = CONT_MAX;
      if (cnt_ff == 2'd1) begin
         if (lead == LEAD_E0) lo = E0_SECOND_MIN;
         else if (lead == LEAD_ED) hi = ED_SECOND_MAX;
         else if (lead == LEAD_F0) lo = F0_SECOND_MIN;
         else if (lead == LEAD_F4) hi = F4_SECOND_MAX;
      end
      need     = (lead < LEAD_E0) ? 3'd2 : (lead < LEAD_F0) ? 3'd3 : 3'd4;
      in_range = (b >= lo) && (b <= hi);
   end

   always_comb begin
      rep       = 2'd0;
      n_data    = 3'd0;
      flush_n   = 2'd0;
      start     = 1'b0;
      store     = 1'b0;
      store_idx = cnt_ff;
      cnt_in    = cnt_ff;
      if (cnt_ff == 2'd0) begin
         start = 1'b1;
      end else if (in_range) begin
         priority if ({1'b0, cnt_ff} + 3'd1 == need) begin
            flush_n = cnt_ff;
            n_data  = {1'b0, cnt_ff} + 3'd1;
            cnt_in  = 2'd0;
         end else if (last) begin
            rep    = 2'd1;
            cnt_in = 2'd0;
         end else if (cnt_ff != 2'd3) begin
            store  = 1'b1;
            cnt_in = cnt_ff + 2'd1;
         end else begin
            rep    = 2'd1;
            cnt_in = 2'd0;
         end
      end else begin
         // drop the held prefix and restart on this byte
         rep    = 2'd1;
         cnt_in = 2'd0;
         start  = 1'b1;
      end
      if (start) begin
         priority if (b < ASCII_LIMIT) begin
            n_data = 3'd1;
         end else if (b >= LEAD_MIN && b <= LEAD_MAX && !last) begin
            store     = 1'b1;
            store_idx = 2'd0;
            cnt_in    = 2'd1;
         end else begin
            rep = rep + 2'd1;
         end
      end
      if (last) cnt_in = 2'd0;
   end

   always_comb begin
      q_cmd.rep_cnt  = rep;
      q_cmd.data_cnt = n_data;
      q_cmd.last     = last;
      for (int k = 0; k < PEND_DEPTH; k++) begin
         q_cmd.data[k] = (2'(k) < flush_n) ? pend_ff[k] : b;
      end
      q_cmd.data[3] = b;
   end

   assign q_push = accept && ((rep != 2'd0) || (n_data != 3'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store) begin
         pend_ff[store_idx] <= b;
      end
   end

endmodule

### rtl/ulr_cmd_queue.sv
`timescale 1ns / 1ps
// Small command FIFO between the front end and the output sequencer.
module ulr_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ulr_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output ulr_pkg::cmd_type head,
   output logic             empty
);
   import ulr_pkg::*;

   cmd_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_PTR_W:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/ulr_back.sv
`timescale 1ns / 1ps
// Back end: expands each command into output bytes, one per cycle unless rsp_ch stalls, into the output register.
module ulr_back (
   input  logic             clock,
   input  logic             reset,
   input  ulr_pkg::cmd_type head,
   input  logic             empty,
   output logic             pop,
   ulr_rsp_if.source        rsp_ch
);
   import ulr_pkg::*;

   logic [2:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       rep_ff, rep_in;
   logic       last_ff, last_in;
   logic       load, at_end;
   logic [2:0] rep_len, total, data_pos, repl_pos;

   assign load    = !empty && (!valid_ff || rsp_ch.ready);
   assign rep_len = {head.rep_cnt, 1'b0} + {1'b0, head.rep_cnt};
   assign total   = rep_len + head.data_cnt;
   assign at_end  = (pos_ff + 3'd1 == total);
   assign pop     = load && at_end;

   always_comb begin
      data_pos = pos_ff - rep_len;
      repl_pos = (pos_ff >= 3'd3) ? pos_ff - 3'd3 : pos_ff;
      rep_in   = (pos_ff < rep_len);
      byte_in  = rep_in ? repl_byte(repl_pos[1:0]) : head.data[data_pos[1:0]];
      last_in  = head.last && at_end;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (load) begin
         pos_in   = at_end ? 3'd0 : pos_ff + 3'd1;
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         rep_ff  <= rep_in;
         last_ff <= last_in;
      end
   end

   assign rsp_ch.valid            = valid_ff;
   assign rsp_ch.out_byte         = byte_ff;
   assign rsp_ch.from_replacement = rep_ff;
   assign rsp_ch.out_last         = last_ff;

endmodule

### rtl/utf8_lossy_repair_unit.sv
`timescale 1ns / 1ps
// Top level of the streaming UTF-8 lossy repair unit.
//
// Streaming UTF-8 repair: raw bytes enter on req_ch, well-formed UTF-8 leaves
// on rsp_ch. Valid sequences (Unicode Table 3-7 ranges, with the narrowed
// second-byte ranges after E0, ED, F0 and F4) pass unchanged, released when
// their final byte arrives. Each maximal invalid subpart becomes one EF BF BD,
// whose three bytes carry from_replacement. A stream that ends inside a
// sequence closes with one replacement; out_last marks the final output byte
// of each stream, and every transaction with in_last set produces output.
// Rate: one input transaction per cycle while the command queue has room, and one
// output transaction per cycle while rsp_ch.ready is high, so unstalled plain ASCII
// flows through at one byte per cycle. Each input transaction that emits anything
// becomes one command for the back end, which emits one output byte per cycle
// unless stalled: 1 byte for ASCII, none while a sequence is held, 2 to 4 when a
// complete sequence is released, 3 per replacement and up to 6 when a held prefix
// and the new byte are both bad. The output port sets the sustained rate; a 4-entry
// command queue absorbs the bursts, and req_ch.ready drops only while it is full.
module utf8_lossy_repair_unit (
   input  logic     clock,
   input  logic     reset,
   ulr_req_if.sink  req_ch,
   ulr_rsp_if.source rsp_ch
);
   import ulr_pkg::*;

   cmd_type push_cmd, head;
   logic    push, full, pop, empty;

   // classify and track the partial sequence
   ulr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (full),
      .q_push (push),
      .q_cmd  (push_cmd)
   );

   // decouple classification from byte emission
   ulr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   // emit replacement and data bytes through the output register
   ulr_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

### tb/sv/utf8_repair_checker.sv
`timescale 1ns / 1ps
// Checker for the UTF-8 lossy repair unit: predicts the repaired byte stream and compares.
module utf8_repair_checker (
   input  logic clock,
   input  logic reset,
   ulr_req_if   req_ch,
   ulr_rsp_if   rsp_ch,
   output int   mismatch_count,
   output int   outstanding,
   output int   checked_count,
   output int   repl_count
);
   import ulr_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       repl;
      logic       last;
   } repaired_type;

   repaired_type repaired_q[$];
   logic [7:0]   held_bytes [PEND_DEPTH];
   logic [1:0]   held_count;

   function automatic void emit(input logic [7:0] b, input logic repl);
      repaired_type e;
      e.data = b;
      e.repl = repl;
      e.last = 1'b0;
      repaired_q = {repaired_q, e};
   endfunction

   function automatic void emit_fffd();
      emit(REPL_BYTE0, 1'b1);
      emit(REPL_BYTE1, 1'b1);
      emit(REPL_BYTE2, 1'b1);
   endfunction

   // Treat a byte as the start of a new sequence.
   function automatic void open_sequence(input logic [7:0] b, input logic last);
      if (b < ASCII_LIMIT) begin
         emit(b, 1'b0);
      end else if (b >= LEAD_MIN && b <= LEAD_MAX) begin
         if (last) begin
            emit_fffd();
         end else begin
            held_bytes[0] = b;
            held_count    = 2'd1;
         end
      end else begin
         emit_fffd();
      end
   endfunction

   function automatic void repair_byte(input logic [7:0] b, input logic last);
      int           mark;
      int           need;
      logic [7:0]   lead;
      logic [7:0]   lo;
      logic [7:0]   hi;
      repaired_type tail;
      mark = repaired_q.size();
      if (held_count == 2'd0) begin
         open_sequence(b, last);
      end else begin
         lead = held_bytes[0];
         lo   = CONT_MIN;
         hi   = CONT_MAX;
         if (held_count == 2'd1) begin
            if (lead == LEAD_E0)      lo = E0_SECOND_MIN;
            else if (lead == LEAD_ED) hi = ED_SECOND_MAX;
            else if (lead == LEAD_F0) lo = F0_SECOND_MIN;
            else if (lead == LEAD_F4) hi = F4_SECOND_MAX;
         end
         need = (lead < LEAD_E0) ? 2 : (lead < LEAD_F0) ? 3 : 4;
         if (b >= lo && b <= hi) begin
            if (int'(held_count) + 1 == need) begin
               for (int k = 0; k < int'(held_count); k++) emit(held_bytes[k], 1'b0);
               emit(b, 1'b0);
               held_count = 2'd0;
            end else if (last) begin
               emit_fffd();
               held_count = 2'd0;
            end else begin
               held_bytes[held_count] = b;
               held_count = held_count + 2'd1;
            end
         end else begin
            // held prefix is one bad subpart; the byte starts over
            emit_fffd();
            held_count = 2'd0;
            open_sequence(b, last);
         end
      end
      if (last) begin
         held_count = 2'd0;
         if (repaired_q.size() > mark) begin
            tail = repaired_q.pop_back();
            tail.last = 1'b1;
            repaired_q = {repaired_q, tail};
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      repaired_type got;
      repaired_type want;
      if (reset) begin
         repaired_q.delete();
         held_count     = 2'd0;
         mismatch_count <= 0;
         outstanding    <= 0;
         checked_count  <= 0;
         repl_count     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) repair_byte(req_ch.in_byte, req_ch.in_last);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.out_byte, rsp_ch.from_replacement, rsp_ch.out_last};
            checked_count <= checked_count + 1;
            if (got.repl) repl_count <= repl_count + 1;
            if (repaired_q.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: unexpected output byte %02h repl %0b last %0b", $realtime,
                           got.data, got.repl, got.last);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = repaired_q.pop_front();
               if (got != want) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display({"%0t: mismatch: expected byte %02h repl %0b last %0b, ",
                               "got byte %02h repl %0b last %0b"},
                              $realtime, want.data, want.repl, want.last,
                              got.data, got.repl, got.last);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         outstanding <= repaired_q.size();
      end
   end

endmodule

### tb/sv/utf8_lossy_repair_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the UTF-8 lossy repair unit: stimulus, back-pressure and verdict.
module utf8_lossy_repair_unit_test;
   import ulr_pkg::*;

   localparam int RANDOM_PER_PHASE = 135;
   localparam int HOLD_CYCLES      = 80;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int DRAIN_CYCLES     = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ulr_req_if req_ch ();
   ulr_rsp_if rsp_ch ();

   int mismatch_count;
   int outstanding;
   int checked_count;
   int repl_count;

   // Sender side: idle percentage, stimulus bytes waiting to go, bytes sent.
   int         send_idle_pct = 26;
   logic [7:0] pattern_q[$];
   int         sent_count    = 0;

   // Receiver side: idle percentage and long hold-off request (toggle handshake).
   int   rsp_idle_pct = 87;
   logic hold_kick    = 1'b0;
   logic hold_seen    = 1'b0;
   int   hold_left    = 0;

   int cycle_count = 0;

   utf8_lossy_repair_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   utf8_repair_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count),
      .repl_count     (repl_count)
   );

   always #2 clock = ~clock;

   // Abort the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver: drop ready at random, or for a long stretch when a hold-off is kicked.
   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen     <= hold_kick;
         hold_left     <= HOLD_CYCLES;
         rsp_ch.ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_ch.ready  <= 1'b0;
      end else begin
         rsp_ch.ready  <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Allowed range of the second byte of a sequence, narrowed after E0, ED, F0, F4.
   function automatic void second_bounds(input  logic [7:0] lead,
                                         output logic [7:0] lo,
                                         output logic [7:0] hi);
      lo = CONT_MIN;
      hi = CONT_MAX;
      if (lead == LEAD_E0)      lo = E0_SECOND_MIN;
      else if (lead == LEAD_ED) hi = ED_SECOND_MAX;
      else if (lead == LEAD_F0) lo = F0_SECOND_MIN;
      else if (lead == LEAD_F4) hi = F4_SECOND_MAX;
   endfunction

   // Queue the first keep bytes of a random well-formed sequence of len bytes.
   task automatic push_valid_prefix(input int len, input int keep);
      logic [7:0] seq [4];
      logic [7:0] lo;
      logic [7:0] hi;
      case (len)
         1: seq[0] = 8'($urandom_range(8'h7F, 8'h00));
         2: seq[0] = 8'($urandom_range(8'hDF, LEAD_MIN));
         3: begin
            // lean on the leads with narrowed second-byte ranges
            if ($urandom_range(2) == 0) seq[0] = $urandom_range(1) ? LEAD_E0 : LEAD_ED;
            else                        seq[0] = 8'($urandom_range(8'hEF, LEAD_E0));
         end
         default: seq[0] = 8'($urandom_range(LEAD_MAX, LEAD_F0));
      endcase
      second_bounds(seq[0], lo, hi);
      seq[1] = 8'($urandom_range(hi, lo));
      seq[2] = 8'($urandom_range(CONT_MAX, CONT_MIN));
      seq[3] = 8'($urandom_range(CONT_MAX, CONT_MIN));
      for (int k = 0; k < keep; k++) pattern_q = {pattern_q, seq[k]};
   endtask

   // Queue one chunk: mostly well-formed text, the rest broken sequences and noise.
   task automatic add_chunk();
      int         kind;
      int         len;
      logic [7:0] lead;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] b;
      kind = $urandom_range(99);
      if (kind < 55) begin
         len = $urandom_range(4, 1);
         push_valid_prefix(len, len);
      end else if (kind < 70) begin
         // truncated sequence: the next chunk cuts it off
         len = $urandom_range(4, 2);
         push_valid_prefix(len, $urandom_range(len - 1, 1));
      end else if (kind < 80) begin
         // lead followed by a byte outside its second-byte range
         lead = 8'($urandom_range(LEAD_MAX, LEAD_MIN));
         second_bounds(lead, lo, hi);
         do b = 8'($urandom_range(255)); while (b >= lo && b <= hi);
         pattern_q = {pattern_q, lead, b};
      end else begin
         repeat ($urandom_range(3, 1)) pattern_q = {pattern_q, 8'($urandom_range(255))};
      end
   endtask

   // Offer one transaction, with random idle cycles ahead of it; hold until accepted.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.in_last <= last;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   // Stop offering and wait until every predicted byte has come out.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      // {in_last, in_byte} pairs for the directed opening
      logic [8:0] opening[$];
      int         phase_start;

      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= 8'h00;
      req_ch.in_last <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      opening = '{
         9'h000, 9'h07F,                  // ASCII extremes
         9'h080, 9'h0C1,                  // stray continuation, impossible lead
         9'h1FF,                          // impossible lead as last byte
         9'h0C2, 9'h080, 9'h0DF, 9'h0BF,  // shortest and longest two-byte forms
         9'h0E0, 9'h0A0, 9'h080,          // lowest three-byte form after E0
         9'h0E0, 9'h09F,                  // overlong second byte after E0
         9'h0ED, 9'h09F, 9'h0BF,          // highest non-surrogate after ED
         9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // top code point
         9'h0F4, 9'h090,                  // beyond the top after F4
         9'h0F0, 9'h190,                  // stream ends inside a four-byte sequence
         9'h1C2                           // valid lead as last byte
      };
      foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);

      // Three back-pressure modes; pause for a full drain between them.
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 87;
            rsp_idle_pct  <= 26;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            rsp_idle_pct  <= 0;
            // hold the receiver off while the sender keeps pushing, to fill the block
            hold_kick     <= ~hold_kick;
         end
         phase_start = sent_count;
         while (sent_count - phase_start < RANDOM_PER_PHASE) begin
            add_chunk();
            while (pattern_q.size() != 0)
               send_byte(pattern_q.pop_front(), $urandom_range(24) == 0);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes: directed edge cases, then valid, truncated and",
               sent_count);
      $display("broken sequences and noise under three back-pressure modes;");
      $display("%0d output bytes checked, %0d replacement.", checked_count, repl_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d bytes still expected", mismatch_count, outstanding);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
